[hw/rtl/cfp_pkg.sv]
// ----------------------------------------------------------------------------
// cfp_pkg: shared types and constants of the framed packet parser
// Status codes, configuration register indexes, parse phases and CRC step.
// ----------------------------------------------------------------------------
package cfp_pkg;

    localparam logic [15:0] CRC_INIT           = 16'hFFFF;
    localparam logic [15:0] CRC_POLY_REFLECTED = 16'h8408;
    localparam logic [16:0] FRAME_OVERHEAD     = 17'd6;

    // configuration register indexes
    localparam logic [2:0] CFG_START_MARKER = 3'd0;
    localparam logic [2:0] CFG_STOP_MARKER  = 3'd1;
    localparam logic [2:0] CFG_MAX_PAYLOAD  = 3'd2;
    localparam logic [2:0] CFG_BUFFER_SIZE  = 3'd3;

    typedef enum logic [2:0] {
        ST_NONE       = 3'd0,
        ST_PAYLOAD    = 3'd1,
        ST_DONE       = 3'd2,
        ST_OVERFLOW   = 3'd3,
        ST_CRC_ERR    = 3'd4,
        ST_FORMAT_ERR = 3'd5
    } status_t;

    typedef enum logic [4:0] {
        PH_HUNT    = 5'b00001,
        PH_LENGTH  = 5'b00010,
        PH_PAYLOAD = 5'b00100,
        PH_CRC     = 5'b01000,
        PH_STOP    = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [7:0]  start_marker;
        logic [7:0]  stop_marker;
        logic [15:0] max_payload;
        logic [15:0] buffer_size;
    } cfg_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic [15:0] frame_length;
    } result_t;

    // one byte of CRC-16/MCRF4XX, LSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY_REFLECTED;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

[hw/rtl/cfp_cfg_regs.sv]
// ----------------------------------------------------------------------------
// cfp_cfg_regs: configuration register file
// Write-only registers for markers, payload limit and buffer size.
// ----------------------------------------------------------------------------
module cfp_cfg_regs
    import cfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_START_MARKER: cfg_next.start_marker = cfg_data[7:0];
                CFG_STOP_MARKER:  cfg_next.stop_marker  = cfg_data[7:0];
                CFG_MAX_PAYLOAD:  cfg_next.max_payload  = cfg_data;
                CFG_BUFFER_SIZE:  cfg_next.buffer_size  = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_marker <= 8'd2;
            cfg_reg.stop_marker  <= 8'd3;
            cfg_reg.max_payload  <= 16'd1024;
            cfg_reg.buffer_size  <= 16'hFFFF;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hw/rtl/cfp_parse_core.sv]
// ----------------------------------------------------------------------------
// cfp_parse_core: frame parser state machine
// Steps the parse state once per accepted byte, the CRC on length/payload bytes, forms the result.
// ----------------------------------------------------------------------------
module cfp_parse_core
    import cfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_take,
    input  logic [7:0]  in_byte,
    input  cfg_t        cfg,
    output result_t     result
);

    phase_t      phase_reg, phase_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crc_low_reg, crc_low_next;

    logic [15:0] crc_upd;
    logic [15:0] len_full;
    logic [16:0] need;
    logic [15:0] count_inc;

    assign crc_upd   = crc_byte(crc_reg, in_byte);
    assign len_full  = {in_byte, len_reg[7:0]};
    assign need      = {1'b0, len_full} + FRAME_OVERHEAD;
    assign count_inc = count_reg + 16'd1;

    always_comb begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        len_next     = len_reg;
        crc_next     = crc_reg;
        crc_low_next = crc_low_reg;
        result       = '{status: ST_NONE, payload_byte: 8'd0,
                         payload_index: 16'd0, frame_length: 16'd0};
        unique case (phase_reg)
            PH_HUNT: begin
                if (in_byte == cfg.start_marker) begin
                    count_next = 16'd0;
                    len_next   = 16'd0;
                    crc_next   = CRC_INIT;
                    phase_next = PH_LENGTH;
                end
            end
            PH_LENGTH: begin
                crc_next = crc_upd;
                if (count_reg == 16'd0) begin
                    len_next   = {8'd0, in_byte};
                    count_next = 16'd1;
                end else begin
                    len_next   = len_full;
                    count_next = 16'd0;
                    if (len_full > cfg.max_payload || need > {1'b0, cfg.buffer_size}) begin
                        phase_next    = PH_HUNT;
                        result.status = ST_OVERFLOW;
                    end else if (len_full == 16'd0) begin
                        phase_next = PH_CRC;
                    end else begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                result.status        = ST_PAYLOAD;
                result.payload_byte  = in_byte;
                result.payload_index = count_reg;
                crc_next             = crc_upd;
                if (count_inc >= len_reg) begin
                    count_next = 16'd0;
                    phase_next = PH_CRC;
                end else begin
                    count_next = count_inc;
                end
            end
            PH_CRC: begin
                if (count_reg == 16'd0) begin
                    crc_low_next = in_byte;
                    count_next   = 16'd1;
                end else begin
                    count_next = 16'd0;
                    if ({in_byte, crc_low_reg} != crc_reg) begin
                        phase_next    = PH_HUNT;
                        result.status = ST_CRC_ERR;
                    end else begin
                        phase_next = PH_STOP;
                    end
                end
            end
            PH_STOP: begin
                phase_next = PH_HUNT;
                if (in_byte != cfg.stop_marker) begin
                    result.status = ST_FORMAT_ERR;
                end else begin
                    result.status       = ST_DONE;
                    result.frame_length = len_reg;
                end
            end
            default: phase_next = PH_HUNT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            count_reg <= 16'd0;
            len_reg   <= 16'd0;
            crc_reg   <= CRC_INIT;
        end else if (in_take) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            len_reg   <= len_next;
            crc_reg   <= crc_next;
        end
    end

    // first CRC byte, always written before it is compared
    always_ff @(posedge aclk) begin
        if (in_take) begin
            crc_low_reg <= crc_low_next;
        end
    end

endmodule

[hw/rtl/cfp_out_buf.sv]
// ----------------------------------------------------------------------------
// cfp_out_buf: result register with skid stage
// Holds results for the output channel; ready drops only when both are full.
// ----------------------------------------------------------------------------
module cfp_out_buf
    import cfp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t push_data,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    pop;

    assign pop = main_valid_reg & out_ready;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!main_valid_reg || pop) begin
                main_next       = push_data;
                main_valid_next = 1'b1;
            end else begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign in_ready  = ~skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

endmodule

[hw/rtl/crc_framed_packet_parser.sv]
// ----------------------------------------------------------------------------
// crc_framed_packet_parser: CRC-16/MCRF4XX framed packet receiver
// Hunts for start/length/payload/CRC/stop frames and reports each word.
// ----------------------------------------------------------------------------
// One received byte is taken per clock while s_ready is high and yields
// exactly one result word, which is registered in the output stage. The
// parse state and a byte-wide CRC update advance together, so a byte can
// be accepted on every clock while s_ready is high. A two-deep output stage
// keeps s_ready high while one result waits; s_ready drops only when two
// results are held. Configuration writes take effect on the next clock.
module crc_framed_packet_parser
    import cfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [7:0]  m_payload_byte,
    output logic [15:0] m_payload_index,
    output logic [15:0] m_frame_length
);

    cfg_t    cfg;
    result_t core_result;
    result_t out_result;
    logic    take;

    assign take = s_valid & s_ready;

    cfp_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cfp_parse_core u_parse_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_take (take),
        .in_byte (s_rx_byte),
        .cfg     (cfg),
        .result  (core_result)
    );

    cfp_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (take),
        .push_data (core_result),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_result)
    );

    assign m_status        = out_result.status;
    assign m_payload_byte  = out_result.payload_byte;
    assign m_payload_index = out_result.payload_index;
    assign m_frame_length  = out_result.frame_length;

    // ready only drops while results are held
    assert property (@(posedge aclk) disable iff (!aresetn) !s_ready |-> m_valid)
        else $error("s_ready low with no result held");

    // reset empties the output stage
    assert property (@(posedge aclk) !aresetn |=> s_ready && !m_valid)
        else $error("output stage not empty after reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_DONE |-> m_frame_length == 16'd0)
        else $error("frame length set on a non-done word");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_PAYLOAD |-> m_payload_byte == 8'd0 && m_payload_index == 16'd0)
        else $error("payload fields set on a non-payload word");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= ST_FORMAT_ERR)
        else $error("status code out of range");

endmodule
